[src/base58_decoder_assert.svh]
// ----------------------------------------------------------------------------
// base58_decoder assertion macros
// Clocked checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BASE58_DECODER_ASSERT_SVH
`define BASE58_DECODER_ASSERT_SVH

// cond must hold at every clock edge
`define B58D_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("base58_decoder: invariant violated");

// ante at an edge implies cons at the same edge
`define B58D_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base58_decoder: implication violated");

// ante at an edge implies cons at the next edge
`define B58D_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base58_decoder: next-cycle check violated");

`endif

[src/b58d_pkg.sv]
// ----------------------------------------------------------------------------
// b58d_pkg
// Shared types, constants and the alphabet lookup for the Base58 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b58d_pkg;

    localparam int MAX_BYTES_DEF = 64;

    localparam logic [7:0] ONE_CHAR = 8'h31;
    localparam logic [7:0] RADIX    = 8'd58;
    localparam logic [6:0] LEAD_MAX = 7'd127;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_last;
    } char_req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] status;
    } byte_req_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } digit_t;

    // Bitcoin alphabet: 1-9 A-H J-N P-Z a-k m-z
    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t d;
        d.ok  = 1'b1;
        d.val = '0;
        priority if (c >= 8'h31 && c <= 8'h39)
        begin
            d.val = 6'(c - 8'h31);
        end
        else if (c >= 8'h41 && c <= 8'h48)
        begin
            d.val = 6'(c - 8'h41 + 8'd9);
        end
        else if (c >= 8'h4A && c <= 8'h4E)
        begin
            d.val = 6'(c - 8'h4A + 8'd17);
        end
        else if (c >= 8'h50 && c <= 8'h5A)
        begin
            d.val = 6'(c - 8'h50 + 8'd22);
        end
        else if (c >= 8'h61 && c <= 8'h6B)
        begin
            d.val = 6'(c - 8'h61 + 8'd33);
        end
        else if (c >= 8'h6D && c <= 8'h7A)
        begin
            d.val = 6'(c - 8'h6D + 8'd44);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[src/b58d_store.sv]
// ----------------------------------------------------------------------------
// b58d_store
// Byte store for the decoded magnitude: one write port, one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module b58d_store #(
    parameter int DEPTH = b58d_pkg::MAX_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/b58d_mac.sv]
// ----------------------------------------------------------------------------
// b58d_mac
// One digit step of the radix-58 multiply: byte * 58 + carry.
// ----------------------------------------------------------------------------
`default_nettype none

module b58d_mac (
    input  wire logic [7:0] byte_in,
    input  wire logic [5:0] carry_in,
    output logic      [7:0] byte_out,
    output logic      [5:0] carry_out
);

    logic [13:0] prod;

    // 255 * 58 + 57 < 2^14, so the carry stays below 58
    assign prod      = 14'(byte_in) * 14'(b58d_pkg::RADIX) + 14'(carry_in);
    assign byte_out  = prod[7:0];
    assign carry_out = prod[13:8];

endmodule

`default_nettype wire

[src/base58_decoder.sv]
// Per character: S_MUL passes one stored byte per cycle through the shared
// multiply-by-58 step and the store (one write port, registered read), then S_APPEND
// appends a nonzero carry. Output: one leading zero per cycle unless byte_stall holds it,
// then a read state and a write state per stored byte (store read is registered).
// Reset: rst_n asynchronous, active low; clears control state, the store is not cleared.
// ----------------------------------------------------------------------------
// base58_decoder
// Serial Base58 (Bitcoin alphabet) decoder with a little-endian byte store.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base58_decoder_assert.svh"

module base58_decoder #(
    parameter int MAX_BYTES = b58d_pkg::MAX_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 char_valid,
    output logic                      char_stall,
    input  wire b58d_pkg::char_req_t  char_req,
    output logic                      byte_valid,
    input  wire logic                 byte_stall,
    output b58d_pkg::byte_req_t       byte_req
);

    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int AW = $clog2(MAX_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_APPEND,
        S_FINISH,
        S_ZEROS,
        S_BYTES_RD,
        S_BYTES_WR
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [5:0]          carry_reg, carry_next;
    logic [6:0]          lead_reg, lead_next;
    logic                still_reg, still_next;
    logic                bad_reg, bad_next;
    logic                ovf_reg, ovf_next;
    logic                last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    b58d_pkg::byte_req_t out_req_reg, out_req_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic [7:0]       mac_byte;
    logic [5:0]       mac_carry;
    logic [CW-1:0]    idx_m1;
    logic [CW-1:0]    cnt_m1;
    logic [7:0]       total;
    logic             slot_free;
    b58d_pkg::digit_t dig;

    b58d_store #(
        .DEPTH (MAX_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    b58d_mac u_mac (
        .byte_in   (rd_data),
        .carry_in  (carry_reg),
        .byte_out  (mac_byte),
        .carry_out (mac_carry)
    );

    assign char_stall = (state_reg != S_IDLE);
    assign byte_valid = out_valid_reg;
    assign byte_req   = out_req_reg;

    assign slot_free = !out_valid_reg || !byte_stall;
    assign idx_m1    = idx_reg - CW'(1);
    assign cnt_m1    = cnt_reg - CW'(1);
    assign total     = {1'b0, lead_reg} + 8'(cnt_reg);
    assign dig       = b58d_pkg::digit_of(char_req.in_char);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        carry_next     = carry_reg;
        lead_next      = lead_reg;
        still_next     = still_reg;
        bad_next       = bad_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && byte_stall;
        out_req_next   = out_req_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (char_valid)
                begin
                    last_next = char_req.is_last;
                    if (still_reg && char_req.in_char == b58d_pkg::ONE_CHAR)
                    begin
                        if (lead_reg != b58d_pkg::LEAD_MAX)
                        begin
                            lead_next = lead_reg + 7'd1;
                        end
                    end
                    else
                    begin
                        still_next = 1'b0;
                    end
                    if (!dig.ok)
                    begin
                        bad_next   = 1'b1;
                        state_next = char_req.is_last ? S_FINISH : S_IDLE;
                    end
                    else
                    begin
                        carry_next = dig.val;
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_MUL;
                    end
                end
            end

            S_MUL:
            begin
                rd_en   = (idx_reg < cnt_reg);
                rd_addr = idx_reg[AW-1:0];
                if (pend_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_m1[AW-1:0];
                    wr_data    = mac_byte;
                    carry_next = mac_carry;
                end
                pend_next = rd_en;
                if (rd_en)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end

            S_APPEND:
            begin
                if (carry_reg != '0)
                begin
                    if (cnt_reg < CW'(MAX_BYTES))
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_reg[AW-1:0];
                        wr_data  = 8'(carry_reg);
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                state_next = last_reg ? S_FINISH : S_IDLE;
            end

            S_FINISH:
            begin
                if (bad_reg || ovf_reg || total > 8'(MAX_BYTES))
                begin
                    if (slot_free)
                    begin
                        out_valid_next        = 1'b1;
                        out_req_next.out_byte = '0;
                        out_req_next.out_last = 1'b1;
                        out_req_next.status   = bad_reg ? b58d_pkg::ST_BAD
                                                        : b58d_pkg::ST_LONG;
                        cnt_next   = '0;
                        lead_next  = '0;
                        still_next = 1'b1;
                        bad_next   = 1'b0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_ZEROS;
                end
            end

            S_ZEROS:
            begin
                if (lead_reg == '0)
                begin
                    state_next = S_BYTES_RD;
                end
                else if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_req_next.out_byte = '0;
                    out_req_next.out_last = (lead_reg == 7'd1) && (cnt_reg == '0);
                    out_req_next.status   = b58d_pkg::ST_OK;
                    lead_next             = lead_reg - 7'd1;
                end
            end

            S_BYTES_RD:
            begin
                if (cnt_reg == '0)
                begin
                    still_next = 1'b1;
                    bad_next   = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cnt_m1[AW-1:0];
                    cnt_next   = cnt_m1;
                    state_next = S_BYTES_WR;
                end
            end

            S_BYTES_WR:
            begin
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    out_req_next.out_byte = rd_data;
                    out_req_next.out_last = (cnt_reg == '0);
                    out_req_next.status   = b58d_pkg::ST_OK;
                    state_next            = S_BYTES_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            carry_reg     <= '0;
            lead_reg      <= '0;
            still_reg     <= 1'b1;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_req_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            carry_reg     <= carry_next;
            lead_reg      <= lead_next;
            still_reg     <= still_next;
            bad_reg       <= bad_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_req_reg   <= out_req_next;
        end
    end

    `B58D_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CW'(MAX_BYTES))
    `B58D_ASSERT_IMPL(a_err_is_last, out_valid_reg && out_req_reg.status != b58d_pkg::ST_OK,
        out_req_reg.out_last && out_req_reg.out_byte == '0)
    `B58D_ASSERT_IMPL(a_wr_only_in_calc, wr_en, state_reg == S_MUL || state_reg == S_APPEND)
    `B58D_ASSERT_NEXT(a_wr_then_read, state_reg == S_BYTES_RD && cnt_reg != '0,
        state_reg == S_BYTES_WR)

endmodule

`default_nettype wire

[tb/sv/tb_base58_decoder.sv]
// ----------------------------------------------------------------------------
// tb_base58_decoder
// Drives Base58 strings one character per request into base58_decoder and
// checks every decoded byte against a behavioral decoder kept in a small
// scoreboard. Covers leading '1' runs, invalid characters, a full store,
// store overflow, over-long output, and random strings with random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_base58_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    MAXB         = b58d_pkg::MAX_BYTES_DEF;
    localparam string B58_ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    class decode_checker;
        logic [7:0]          mag [MAXB];
        int unsigned         nbytes;
        int unsigned         nlead;
        bit                  leading;
        bit                  bad;
        bit                  ovf;
        b58d_pkg::byte_req_t expected_bytes[$];
        int                  mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            foreach (mag[i])
            begin
                mag[i] = '0;
            end
            nbytes  = 0;
            nlead   = 0;
            leading = 1'b1;
            bad     = 1'b0;
            ovf     = 1'b0;
        endfunction

        function int digit_value(logic [7:0] c);
            for (int i = 0; i < 58; i++)
            begin
                if (B58_ALPHABET[i] == c)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void push_byte(logic [7:0] b, logic l, logic [1:0] s);
            b58d_pkg::byte_req_t e;
            e.out_byte = b;
            e.out_last = l;
            e.status   = s;
            expected_bytes = {expected_bytes, e};
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // decode one accepted character; on the last one queue the output bytes
        function void absorb_char(b58d_pkg::char_req_t r);
            int          d;
            int unsigned carry;
            int unsigned x;
            d = digit_value(r.in_char);
            if (leading && r.in_char == b58d_pkg::ONE_CHAR)
            begin
                if (nlead < b58d_pkg::LEAD_MAX)
                begin
                    nlead++;
                end
            end
            else
            begin
                leading = 1'b0;
            end
            if (d < 0)
            begin
                bad = 1'b1;
            end
            else
            begin
                carry = unsigned'(d);
                for (int i = 0; i < nbytes; i++)
                begin
                    x      = int'(mag[i]) * int'(b58d_pkg::RADIX) + carry;
                    mag[i] = x[7:0];
                    carry  = x >> 8;
                end
                if (carry != 0)
                begin
                    if (nbytes < MAXB)
                    begin
                        mag[nbytes] = carry[7:0];
                        nbytes++;
                    end
                    else
                    begin
                        ovf = 1'b1;
                    end
                end
            end
            if (!r.is_last)
            begin
                return;
            end
            if (bad || ovf || nlead + nbytes > MAXB)
            begin
                push_byte(8'h00, 1'b1, bad ? b58d_pkg::ST_BAD : b58d_pkg::ST_LONG);
            end
            else
            begin
                for (int k = 0; k < nlead; k++)
                begin
                    push_byte(8'h00, 1'b0, b58d_pkg::ST_OK);
                end
                for (int k = nbytes; k > 0; k--)
                begin
                    push_byte(mag[k - 1], 1'b0, b58d_pkg::ST_OK);
                end
                if (nlead + nbytes > 0)
                begin
                    expected_bytes[expected_bytes.size() - 1].out_last = 1'b1;
                end
            end
            clear();
        endfunction

        function void match_byte(b58d_pkg::byte_req_t got);
            b58d_pkg::byte_req_t e;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t unexpected byte %02h last %b status %0d",
                             $realtime, got.out_byte, got.out_last, got.status);
                end
                return;
            end
            e = expected_bytes.pop_front();
            if (got.out_byte !== e.out_byte || got.out_last !== e.out_last ||
                got.status !== e.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t byte mismatch: exp %02h/%b/%0d got %02h/%b/%0d",
                             $realtime, e.out_byte, e.out_last, e.status,
                             got.out_byte, got.out_last, got.status);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                char_valid;
    logic                char_stall;
    b58d_pkg::char_req_t char_req;
    logic                byte_valid;
    logic                byte_stall = 1'b0;
    b58d_pkg::byte_req_t byte_req;

    decode_checker board = new();
    bit            calm;
    int            items_sent;
    logic [7:0]    chars_q[$];

    base58_decoder #(
        .MAX_BYTES(MAXB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .char_valid(char_valid),
        .char_stall(char_stall),
        .char_req(char_req),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_req(byte_req)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(negedge clk)
    begin
        byte_stall = rst_n && !calm && ($urandom_range(99) < 9);
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
        begin
            board.match_byte(byte_req);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 9)
        begin
            char_valid = 1'b0;
            @(negedge clk);
        end
        char_valid       = 1'b1;
        char_req.in_char = c;
        char_req.is_last = last;
        do
        begin
            @(posedge clk);
        end
        while (char_stall);
        board.absorb_char(char_req);
        items_sent++;
    endtask

    task automatic add_char(input logic [7:0] c);
        chars_q = {chars_q, c};
    endtask

    task automatic send_string();
        foreach (chars_q[i])
        begin
            send_char(chars_q[i], i == chars_q.size() - 1);
        end
        chars_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            add_char(s[i]);
        end
        send_string();
    endtask

    task automatic add_repeat(input logic [7:0] c, input int n);
        repeat (n)
        begin
            add_char(c);
        end
    endtask

    task automatic add_digits(input int n);
        repeat (n)
        begin
            add_char(B58_ALPHABET[$urandom_range(57)]);
        end
    endtask

    task automatic wait_drain();
        @(negedge clk);
        char_valid = 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int         waited;
        int         kind;
        int         pos;
        int         nstr;
        logic [7:0] junk;
        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_req   = '0;
        calm       = 1'b0;
        items_sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // short directed strings
        send_text("1");
        send_text("z");
        send_text("11z");
        send_text("z1");
        send_text("1z1");
        send_text("0");
        send_text("zl");
        send_text("I");
        send_text("O");
        add_char(8'h31);
        add_char(8'h00);
        add_char(8'hFF);
        send_string();
        add_char(8'h80);
        add_char(8'h7A);
        send_string();
        send_text("2A");

        wait_drain();

        // random strings, mostly well formed
        nstr = 0;
        while (items_sent < 92)
        begin
            calm = (nstr >= 3 && nstr < 8);
            kind = $urandom_range(99);
            if ($urandom_range(2) == 0)
            begin
                add_repeat(b58d_pkg::ONE_CHAR, $urandom_range(1, 3));
            end
            if (kind < 88)
            begin
                add_digits($urandom_range(1, 14));
            end
            if (kind >= 75 && kind < 88)
            begin
                do
                begin
                    junk = 8'($urandom_range(255));
                end
                while (board.digit_value(junk) >= 0);
                pos          = $urandom_range(chars_q.size() - 1);
                chars_q[pos] = junk;
            end
            else if (kind >= 88)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    add_char(8'($urandom_range(255)));
                end
            end
            send_string();
            nstr++;
        end
        calm = 1'b0;

        // store and output length boundaries
        add_repeat(b58d_pkg::ONE_CHAR, 65);
        send_string();
        add_repeat("z", 87);
        send_string();
        add_repeat("z", 88);
        send_string();

        wait_drain();
        waited = 0;
        while (board.pending() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (300) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
